[rtl/stt_pkg.sv]
// Shared types, constants and character-class helpers for the source text tokenizer.
package stt_pkg;

  localparam int CHAR_W             = 8;
  localparam int KIND_W             = 5;
  localparam int FIELD_W            = 16;
  localparam int OFFSET_BITS_DEF    = 16;
  localparam int MAX_KW_LEN_DEF     = 6;
  localparam int KW_TEXT_W          = 64;
  localparam int KW_LEN_W           = 4;
  localparam int KW_COUNT           = 15;
  localparam int OP_COUNT           = 7;
  localparam int SLOTS              = 3;

  localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd0;
  localparam logic [KIND_W-1:0] KIND_INT     = 5'd1;
  localparam logic [KIND_W-1:0] KIND_KW0     = 5'd2;
  localparam logic [KIND_W-1:0] KIND_OP0     = 5'd17;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL = 5'd24;
  localparam logic [KIND_W-1:0] KIND_END     = 5'd25;

  // Keyword text packed with the first character in the lowest byte, so each
  // literal below is the keyword spelled backwards.
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
    64'("fed"),   64'("ssalc"), 64'("tcurts"), 64'("fi"),    64'("esle"),
    64'("elihw"), 64'("rof"),   64'("nruter"), 64'("23tni"), 64'("taolf"),
    64'("loob"),  64'("rahc"),  64'("tsil"),   64'("eurt"),  64'("eslaf")
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd5, 4'd6, 4'd2, 4'd4, 4'd5, 4'd3, 4'd6, 4'd5, 4'd5,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd5
  };

  localparam logic [CHAR_W-1:0] OP_CHAR [OP_COUNT] = '{
    8'h3D, 8'h3B, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2B
  };

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [CHAR_W-1:0]  ch;
  } result_t;

  // Up to three results per byte: the closed run, a single-byte token or the
  // run closed by end of source, and the end token.
  typedef struct packed {
    logic [SLOTS-1:0] vld;
    result_t [SLOTS-1:0] slot;
  } bundle_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_under(input logic [CHAR_W-1:0] c);
    return c == 8'h5F;
  endfunction

  function automatic logic [KIND_W-1:0] op_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    k = KIND_ILLEGAL;
    for (int i = 0; i < OP_COUNT; i++) begin
      if (OP_CHAR[i] == c) k = KIND_OP0 + KIND_W'(i);
    end
    return k;
  endfunction

endpackage

[rtl/stt_in_if.sv]
// Request channel carrying one source byte and its end-of-source flag.
interface stt_in_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::CHAR_W-1:0]  char_byte;
  logic                        end_of_source;

  modport source (output valid, char_byte, end_of_source, input ready);
  modport sink   (input valid, char_byte, end_of_source, output ready);
endinterface

[rtl/stt_out_if.sv]
// Result channel carrying the tokens that each request yields, with last on the final one.
interface stt_out_if;
  logic                        valid;
  logic                        ready;
  logic [stt_pkg::KIND_W-1:0]  token_kind;
  logic [stt_pkg::FIELD_W-1:0] start_offset;
  logic [stt_pkg::FIELD_W-1:0] token_length;
  logic [stt_pkg::CHAR_W-1:0]  single_char;
  logic                        last;

  modport source (output valid, token_kind, start_offset, token_length, single_char, last,
                  input ready);
  modport sink   (input valid, token_kind, start_offset, token_length, single_char, last,
                  output ready);
endinterface

[rtl/stt_kw_match.sv]
// Parallel keyword comparator over the captured identifier prefix.
module stt_kw_match #(
  parameter int OFFSET_BITS        = stt_pkg::OFFSET_BITS_DEF,
  parameter int MAX_KEYWORD_LENGTH = stt_pkg::MAX_KW_LEN_DEF
) (
  input  logic [MAX_KEYWORD_LENGTH*8-1:0] window,
  input  logic [OFFSET_BITS-1:0]          run_len,
  output logic [stt_pkg::KIND_W-1:0]      kind
);

  localparam int TW = stt_pkg::KW_TEXT_W;
  localparam int KW = stt_pkg::KIND_W;

  logic [TW-1:0] win_ext;

  assign win_ext = TW'(window);

  always_comb begin
    kind = stt_pkg::KIND_IDENT;
    if (run_len <= OFFSET_BITS'(MAX_KEYWORD_LENGTH)) begin
      for (int k = 0; k < stt_pkg::KW_COUNT; k++) begin
        if ((run_len == OFFSET_BITS'(stt_pkg::KW_LEN[k])) && (win_ext == stt_pkg::KW_TEXT[k]))
          kind = stt_pkg::KIND_KW0 + KW'(k);
      end
    end
  end

endmodule

[rtl/stt_lexer.sv]
// Run-state register and per-byte token logic producing a bundle of up to three results.
module stt_lexer #(
  parameter int OFFSET_BITS        = stt_pkg::OFFSET_BITS_DEF,
  parameter int MAX_KEYWORD_LENGTH = stt_pkg::MAX_KW_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [stt_pkg::CHAR_W-1:0] char_byte,
  input  logic                       end_of_source,
  output stt_pkg::bundle_t           bundle
);

  localparam int OB = OFFSET_BITS;
  localparam int WW = MAX_KEYWORD_LENGTH * 8;
  localparam int FW = stt_pkg::FIELD_W;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_DONE   = 2'd3;

  localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};

  logic [1:0]    mode_r,  mode_nxt;
  logic [OB-1:0] off_r,   off_nxt;
  logic [OB-1:0] start_r, start_nxt;
  logic [OB-1:0] len_r,   len_nxt;
  logic [WW-1:0] win_r,   win_nxt;

  // Run as it stands after this byte, before any end-of-source close.
  logic [1:0]    pm;
  logic [OB-1:0] ps, pl;
  logic [WW-1:0] pw;
  logic          close_old, single_tok, in_word, is_alnum;
  logic [OB-1:0] off_inc, len_inc;
  logic [stt_pkg::KIND_W-1:0] kind_old, kind_new;
  stt_pkg::result_t res_old;

  stt_kw_match #(.OFFSET_BITS(OB), .MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH)) u_kw_old (
    .window (win_r),
    .run_len(len_r),
    .kind   (kind_old)
  );

  stt_kw_match #(.OFFSET_BITS(OB), .MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH)) u_kw_new (
    .window (pw),
    .run_len(pl),
    .kind   (kind_new)
  );

  assign off_inc  = (off_r == OFF_MAX) ? off_r : off_r + 1'b1;
  assign len_inc  = (len_r == OFF_MAX) ? len_r : len_r + 1'b1;
  assign is_alnum = stt_pkg::is_alpha(char_byte) || stt_pkg::is_digit(char_byte) ||
                    stt_pkg::is_under(char_byte);
  assign in_word  = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER);

  always_comb begin
    res_old.kind  = (mode_r == MODE_IDENT) ? kind_old : stt_pkg::KIND_INT;
    res_old.start = FW'(start_r);
    res_old.len   = FW'(len_r);
    res_old.ch    = '0;
  end

  always_comb begin
    pm         = mode_r;
    ps         = start_r;
    pl         = len_r;
    pw         = win_r;
    close_old  = 1'b0;
    single_tok = 1'b0;
    if ((mode_r == MODE_IDENT) && is_alnum) begin
      for (int j = 0; j < MAX_KEYWORD_LENGTH; j++) begin
        if (len_r == OB'(j)) pw[j*8 +: 8] = char_byte;
      end
      pl = len_inc;
    end else if ((mode_r == MODE_NUMBER) && stt_pkg::is_digit(char_byte)) begin
      pl = len_inc;
    end else begin
      close_old = in_word;
      pm        = MODE_IDLE;
      pl        = '0;
      pw        = '0;
      if (stt_pkg::is_space(char_byte)) begin
        pm = MODE_IDLE;
      end else if (stt_pkg::is_alpha(char_byte) || stt_pkg::is_under(char_byte)) begin
        pm = MODE_IDENT;
        ps = off_r;
        pl = OB'(1);
        pw = WW'(char_byte);
      end else if (stt_pkg::is_digit(char_byte)) begin
        pm = MODE_NUMBER;
        ps = off_r;
        pl = OB'(1);
      end else begin
        single_tok = 1'b1;
      end
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    off_nxt   = off_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    win_nxt   = win_r;
    bundle    = '0;
    if (acc) begin
      if (mode_r == MODE_DONE) begin
        if (end_of_source) begin
          mode_nxt  = MODE_IDLE;
          off_nxt   = '0;
          start_nxt = '0;
        end
      end else if (char_byte == '0) begin
        bundle.vld[0]        = in_word;
        bundle.slot[0]       = res_old;
        bundle.vld[2]        = 1'b1;
        bundle.slot[2].kind  = stt_pkg::KIND_END;
        bundle.slot[2].start = FW'(off_r);
        len_nxt = '0;
        win_nxt = '0;
        if (end_of_source) begin
          mode_nxt  = MODE_IDLE;
          off_nxt   = '0;
          start_nxt = '0;
        end else begin
          mode_nxt = MODE_DONE;
        end
      end else begin
        bundle.vld[0]  = close_old;
        bundle.slot[0] = res_old;
        if (single_tok) begin
          bundle.vld[1]        = 1'b1;
          bundle.slot[1].kind  = stt_pkg::op_kind(char_byte);
          bundle.slot[1].start = FW'(off_r);
          bundle.slot[1].len   = FW'(1);
          bundle.slot[1].ch    = char_byte;
        end
        if (end_of_source) begin
          if ((pm == MODE_IDENT) || (pm == MODE_NUMBER)) begin
            bundle.vld[1]        = 1'b1;
            bundle.slot[1].kind  = (pm == MODE_IDENT) ? kind_new : stt_pkg::KIND_INT;
            bundle.slot[1].start = FW'(ps);
            bundle.slot[1].len   = FW'(pl);
          end
          bundle.vld[2]        = 1'b1;
          bundle.slot[2].kind  = stt_pkg::KIND_END;
          bundle.slot[2].start = FW'(off_inc);
          mode_nxt  = MODE_IDLE;
          off_nxt   = '0;
          start_nxt = '0;
          len_nxt   = '0;
          win_nxt   = '0;
        end else begin
          mode_nxt  = pm;
          off_nxt   = off_inc;
          start_nxt = ps;
          len_nxt   = pl;
          win_nxt   = pw;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      off_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
      win_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      win_r   <= win_nxt;
    end
  end

  // End of source always rewinds the offset for the next source.
  a_eos_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    acc && end_of_source |=> off_r == '0)
    else $error("offset not rewound after end of source");

  // The finished mode never holds a pending run.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == MODE_DONE |-> len_r == '0 && win_r == '0)
    else $error("pending run left in finished mode");

  // Every terminating request outside finished mode yields an end token.
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    acc && mode_r != MODE_DONE && (end_of_source || char_byte == '0) |-> bundle.vld[2])
    else $error("missing end token");

endmodule

[rtl/stt_emit.sv]
// Result register holding one bundle and handing its tokens out one per cycle while out_ready is high.
module stt_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  stt_pkg::bundle_t  bundle,
  input  logic              out_ready,
  output logic              out_valid,
  output stt_pkg::result_t  out_res,
  output logic              out_last,
  output logic              can_load
);

  localparam int NS = stt_pkg::SLOTS;

  logic [NS-1:0]              vld_r, vld_nxt;
  stt_pkg::result_t [NS-1:0] slot_r;
  logic [1:0]                 sel;
  logic [NS-1:0]              sel_mask, vld_rem;

  always_comb begin
    if (vld_r[0]) begin
      sel = 2'd0;
    end else if (vld_r[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
  end

  assign sel_mask  = NS'(1) << sel;
  assign vld_rem   = vld_r & ~sel_mask;
  assign out_valid = |vld_r;
  assign out_res   = slot_r[sel];
  assign out_last  = (vld_rem == '0);
  // A new bundle may land once the one held is gone or leaves this cycle.
  assign can_load  = (vld_r == '0) || (out_ready && $onehot(vld_r));

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = bundle.vld;
    end else if (out_valid && out_ready) begin
      vld_nxt = vld_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) slot_r <= bundle.slot;
  end

  a_last_marks_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == $onehot(vld_r)))
    else $error("last flag disagrees with pending results");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (vld_r == '0) || (out_ready && $onehot(vld_r)))
    else $error("bundle loaded over undelivered results");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && bundle.vld != '0 |=> out_valid)
    else $error("loaded results not presented");

endmodule

[rtl/source_text_tokenizer.sv]
// Top level of the source text tokenizer: lexer state, keyword match and result register.
//
// The tokenizer takes one source byte per request and returns tokens (kind, start offset,
// length, operator byte) on the result channel, with last set on the final token that a
// byte causes. A byte causes zero to three tokens: the run it closes, a single-byte operator
// or illegal token (or, on end of source, the run it leaves open), and the end token. Each
// byte is classified, the run state updated and its tokens built in the same cycle it is
// accepted; the tokens then sit in a three-slot result register and leave one per cycle
// while the result channel is ready, so ordinary text streams at one byte per cycle; a byte
// that yields more tokens holds the input while the result register drains, with the next
// byte accepted in the cycle the last of them is taken. Keywords are matched by fifteen
// parallel compares on the first MAX_KEYWORD_LENGTH bytes of an identifier. After a zero
// byte everything up to the end-of-source byte is dropped. Offsets and lengths count in
// OFFSET_BITS bits and saturate at their maximum; the output fields carry their low 16 bits.
module source_text_tokenizer #(
  parameter int OFFSET_BITS        = stt_pkg::OFFSET_BITS_DEF,
  parameter int MAX_KEYWORD_LENGTH = stt_pkg::MAX_KW_LEN_DEF
) (
  input logic        clk,
  input logic        rst_n,
  stt_in_if.sink     in_if,
  stt_out_if.source  out_if
);

  logic             acc;
  logic             can_load;
  stt_pkg::bundle_t bundle;
  stt_pkg::result_t out_res;

  assign in_if.ready = can_load;
  assign acc         = in_if.valid && can_load;

  stt_lexer #(.OFFSET_BITS(OFFSET_BITS), .MAX_KEYWORD_LENGTH(MAX_KEYWORD_LENGTH)) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .char_byte    (in_if.char_byte),
    .end_of_source(in_if.end_of_source),
    .bundle       (bundle)
  );

  // Every accepted byte loads the result register, even when it yields nothing,
  // which simply leaves the register empty.
  stt_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (acc),
    .bundle   (bundle),
    .out_ready(out_if.ready),
    .out_valid(out_if.valid),
    .out_res  (out_res),
    .out_last (out_if.last),
    .can_load (can_load)
  );

  assign out_if.token_kind   = out_res.kind;
  assign out_if.start_offset = out_res.start;
  assign out_if.token_length = out_res.len;
  assign out_if.single_char  = out_res.ch;

endmodule

[verif/stt_checker.sv]
`timescale 1ns / 100ps
// Token predictor and result comparator that watches both channels of the tokenizer.
module stt_checker (
  input  logic clk,
  input  logic rst_n,
  stt_in_if    in_ch,
  stt_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import stt_pkg::*;

  localparam logic [FIELD_W-1:0] FIELD_MAX = 16'hFFFF;
  localparam int KEYWORD_SPAN = 6;
  localparam int REPORT_CAP = 200;

  typedef enum logic [1:0] {LEX_IDLE, LEX_IDENT, LEX_NUMBER, LEX_DONE} lex_mode_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] len;
    logic [CHAR_W-1:0]  ch;
    logic               last;
  } token_t;

  string keyword_words [15] = '{
    "def", "class", "struct", "if", "else", "while", "for", "return",
    "int32", "float", "bool", "char", "list", "true", "false"
  };
  string operator_chars = "=;(){}+";

  lex_mode_e          lex_mode;
  logic [FIELD_W-1:0] byte_pos;
  logic [FIELD_W-1:0] word_start;
  logic [FIELD_W-1:0] word_len;
  logic [47:0]        word_window;
  token_t             new_tokens[$];
  token_t             expected_tokens[$];
  int                 errors = 0;
  int                 reports = 0;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_numeral(input logic [CHAR_W-1:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
    return (v == FIELD_MAX) ? v : v + 16'd1;
  endfunction

  function automatic void add_token(input logic [KIND_W-1:0] kind,
                                    input logic [FIELD_W-1:0] start,
                                    input logic [FIELD_W-1:0] len,
                                    input logic [CHAR_W-1:0] ch);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = len;
    t.ch    = ch;
    t.last  = 1'b0;
    new_tokens.push_back(t);
  endfunction

  // Short identifiers are compared against every keyword, spelled first byte lowest.
  function automatic logic [KIND_W-1:0] word_kind();
    logic [47:0]       kw_text;
    logic [KIND_W-1:0] kind;
    kind = KIND_IDENT;
    if (word_len <= KEYWORD_SPAN) begin
      for (int k = 0; k < 15; k++) begin
        kw_text = '0;
        for (int i = 0; i < keyword_words[k].len(); i++)
          kw_text |= 48'(keyword_words[k][i]) << (8 * i);
        if (word_len == 16'(keyword_words[k].len()) && kw_text == word_window)
          kind = KIND_KW0 + 5'(k);
      end
    end
    return kind;
  endfunction

  function automatic void reset_lexer();
    lex_mode    = LEX_IDLE;
    byte_pos    = '0;
    word_start  = '0;
    word_len    = '0;
    word_window = '0;
  endfunction

  function automatic void close_word();
    if (lex_mode == LEX_IDENT) add_token(word_kind(), word_start, word_len, 8'd0);
    else if (lex_mode == LEX_NUMBER) add_token(KIND_INT, word_start, word_len, 8'd0);
    lex_mode    = LEX_IDLE;
    word_len    = '0;
    word_window = '0;
  endfunction

  function automatic void start_word(input lex_mode_e mode, input logic [CHAR_W-1:0] c);
    lex_mode    = mode;
    word_start  = byte_pos;
    word_len    = 16'd1;
    word_window = (mode == LEX_IDENT) ? 48'(c) : '0;
  endfunction

  function automatic void tokenize_byte(input logic [CHAR_W-1:0] c, input logic eos);
    logic [KIND_W-1:0] kind;
    token_t            t;
    new_tokens.delete();
    if (lex_mode == LEX_DONE) begin
      if (eos) reset_lexer();
      return;
    end
    if (c == 8'd0) begin
      close_word();
      add_token(KIND_END, byte_pos, 16'd0, 8'd0);
      if (eos) reset_lexer();
      else lex_mode = LEX_DONE;
    end else begin
      if (lex_mode == LEX_IDENT && (is_letter(c) || is_numeral(c) || c == "_")) begin
        if (word_len < KEYWORD_SPAN) word_window |= 48'(c) << (8 * word_len);
        word_len = bump(word_len);
      end else if (lex_mode == LEX_NUMBER && is_numeral(c)) begin
        word_len = bump(word_len);
      end else begin
        close_word();
        if (is_letter(c) || c == "_") begin
          start_word(LEX_IDENT, c);
        end else if (is_numeral(c)) begin
          start_word(LEX_NUMBER, c);
        end else if (!is_blank(c)) begin
          kind = KIND_ILLEGAL;
          for (int i = 0; i < 7; i++)
            if (8'(operator_chars[i]) == c) kind = KIND_OP0 + 5'(i);
          add_token(kind, byte_pos, 16'd1, c);
        end
      end
      byte_pos = bump(byte_pos);
      if (eos) begin
        close_word();
        add_token(KIND_END, byte_pos, 16'd0, 8'd0);
        reset_lexer();
      end
    end
    if (new_tokens.size() > 0) begin
      t = new_tokens.pop_back();
      t.last = 1'b1;
      new_tokens.push_back(t);
    end
    foreach (new_tokens[i]) expected_tokens.push_back(new_tokens[i]);
  endfunction

  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst_n) begin
      reset_lexer();
      expected_tokens.delete();
    end else begin
      // A result taken at this edge belongs to a request accepted earlier, so it is
      // matched before this edge's request adds its own expectations.
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.kind  = out_ch.token_kind;
        got.start = out_ch.start_offset;
        got.len   = out_ch.token_length;
        got.ch    = out_ch.single_char;
        got.last  = out_ch.last;
        if (expected_tokens.size() == 0) begin
          errors++;
          if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t: unexpected token: expected none, got kind %0d start %0d len %0d char %0d last %0d",
                     $time, got.kind, got.start, got.len, got.ch, got.last);
          end
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            errors++;
            if (reports < REPORT_CAP) begin
              reports++;
              $display("%0t: token mismatch: expected kind %0d start %0d len %0d char %0d last %0d, got kind %0d start %0d len %0d char %0d last %0d",
                       $time, want.kind, want.start, want.len, want.ch, want.last,
                       got.kind, got.start, got.len, got.ch, got.last);
            end
          end
        end
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        tokenize_byte(in_ch.char_byte, in_ch.end_of_source);
    end
    fail_count <= errors;
    pending    <= expected_tokens.size();
  end

endmodule

[verif/tb_source_text_tokenizer.sv]
`timescale 1ns / 100ps
// Testbench top for the source text tokenizer: clock, reset, byte stimulus and the verdict.
module tb_source_text_tokenizer;
  import stt_pkg::*;

  // Least number of requests that the block actually reads, directed ones included; bytes
  // dropped after a zero byte do not count.
  localparam int RANDOM_ITEMS    = 360;
  // Requests at the end of the run that are sent with no idling on either side.
  localparam int FINAL_CALM      = 40;
  // The limit leaves ample margin over the slowest correct run.
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [CHAR_W-1:0] c;
    logic              eos;
  } src_byte_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   counted_items;
  bit   after_zero = 1'b0;
  bit   no_idling = 1'b0;

  src_byte_t src_bytes[$];

  string keyword_list [15] = '{
    "def", "class", "struct", "if", "else", "while", "for", "return",
    "int32", "float", "bool", "char", "list", "true", "false"
  };
  string operator_list = "=;(){}+";

  stt_in_if  in_ch ();
  stt_out_if out_ch ();

  source_text_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  stt_checker u_token_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Queue one source byte. The block reads every byte until a zero byte, and then drops
  // everything up to the byte that carries end of source; only read bytes are counted.
  function automatic void push_byte(input logic [CHAR_W-1:0] c, input logic eos);
    src_bytes.push_back('{c: c, eos: eos});
    if (after_zero) begin
      if (eos) after_zero = 1'b0;
    end else begin
      counted_items++;
      if (c == 8'd0 && !eos) after_zero = 1'b1;
    end
  endfunction

  function automatic void push_word(input string s, input logic eos_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], eos_last && i == s.len() - 1);
  endfunction

  function automatic logic [CHAR_W-1:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [CHAR_W-1:0] word_head();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [CHAR_W-1:0] blank_char();
    int r;
    r = $urandom_range(9, 14);
    return (r == 14) ? 8'd32 : 8'(r);
  endfunction

  // Directed text: each operator, identifiers with digits and underscores, a number run
  // into an identifier, illegal high bytes, a zero byte and the dropped bytes after it,
  // end of source on a dropped byte, on a digit and together with a zero byte.
  function automatic void build_directed();
    push_word("if(x1)=_9;", 1'b0);
    push_word("{}+", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h09, 1'b0);
    push_word("12ab", 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte("z", 1'b0);
    push_byte("q", 1'b1);
    push_byte("7", 1'b1);
    push_byte(8'h00, 1'b1);
  endfunction

  // Mostly well-formed token streams (keywords, near-keywords, identifiers, numbers,
  // operators) with some noise bytes, zero bytes and sources that end mid-token.
  function automatic void build_random();
    int    pick;
    int    n;
    bit    eos_last;
    string w;
    while (counted_items < RANDOM_ITEMS) begin
      pick     = $urandom_range(0, 99);
      eos_last = ($urandom_range(0, 19) == 0);
      if (pick < 25) begin
        w = keyword_list[$urandom_range(0, 14)];
        n = $urandom_range(0, 9);
        if (n < 2) begin
          // A keyword with one more identifier byte is a plain identifier.
          push_word(w, 1'b0);
          push_byte(word_char(), eos_last);
        end else if (n < 3) begin
          // A keyword prefix is a plain identifier too.
          for (int i = 0; i < w.len() - 1; i++) push_byte(w[i], eos_last && i == w.len() - 2);
        end else begin
          push_word(w, eos_last);
        end
      end else if (pick < 45) begin
        n = $urandom_range(1, 10);
        push_byte(word_head(), eos_last && n == 1);
        for (int i = 1; i < n; i++) push_byte(word_char(), eos_last && i == n - 1);
      end else if (pick < 58) begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_byte(8'("0" + $urandom_range(0, 9)), eos_last && i == n - 1);
      end else if (pick < 72) begin
        push_byte(operator_list[$urandom_range(0, 6)], eos_last);
      end else if (pick < 82) begin
        push_byte(8'($urandom_range(0, 255)), eos_last);
      end else if (pick < 87) begin
        push_byte(8'h00, $urandom_range(0, 3) == 0);
        if (after_zero) begin
          repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
          push_byte(8'($urandom_range(0, 255)), 1'b1);
        end
      end else if (pick < 92) begin
        push_byte(8'($urandom_range(1, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) push_byte(blank_char(), 1'b0);
      end
      if (pick < 72 && $urandom_range(0, 9) < 7) push_byte(blank_char(), 1'b0);
    end
    // Close the last source.
    push_byte(8'd32, 1'b1);
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_byte(input logic [CHAR_W-1:0] c, input logic eos);
    in_ch.valid         <= 1'b1;
    in_ch.char_byte     <= c;
    in_ch.end_of_source <= eos;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Result side: random stalls, with calm windows that have none, and
  // always ready once the final phase begins.
  initial begin
    int stall_left;
    int window_pos;
    bit ready_calm;
    stall_left = 0;
    window_pos = 0;
    ready_calm = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      window_pos++;
      if (window_pos == 64) begin
        window_pos = 0;
        ready_calm = ($urandom_range(0, 3) == 0);
      end
      if (no_idling) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!ready_calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    in_ch.valid         <= 1'b0;
    in_ch.char_byte     <= '0;
    in_ch.end_of_source <= 1'b0;
    rst_n               <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    build_random();

    // Request side: random gaps, but none in the first part of every 80 bytes,
    // and none on either side for the last requests of the run.
    foreach (src_bytes[i]) begin
      if (i == src_bytes.size() - FINAL_CALM) no_idling = 1'b1;
      if (!no_idling && (i % 80) >= 20 && $urandom_range(0, 7) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      send_byte(src_bytes[i].c, src_bytes[i].eos);
    end
    no_idling = 1'b1;
    in_ch.valid <= 1'b0;

    // The pending count is registered, so let it update before reading it.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/stt_pkg.sv
rtl/stt_in_if.sv
rtl/stt_out_if.sv
rtl/stt_kw_match.sv
rtl/stt_lexer.sv
rtl/stt_emit.sv
rtl/source_text_tokenizer.sv
verif/stt_checker.sv
verif/tb_source_text_tokenizer.sv
